[hdl/qvr_pkg.sv]
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared widths and types of the quaternion vector rotation pipeline.
// ----------------------------------------------------------------------------
package qvr_pkg;

	// quaternion part width (Q2.14)
	localparam int QUAT_W        = 16;
	// one product of two quaternion parts
	localparam int SQ_W          = 2 * QUAT_W;
	// rotation matrix entry (unnormalized), signed
	localparam int MAT_W         = SQ_W + 2;
	// squared norm of the quaternion, unsigned
	localparam int NRM_W         = SQ_W + 1;
	// default vector coordinate width (Q8.8)
	localparam int VEC_WIDTH_DEF = 16;

	// per item sideband that rides along the divider
	typedef struct packed {
		logic [2:0] neg;   // sign of each dot product
		logic       zero;  // quaternion is all zero
	} side_t;

endpackage

[hdl/qvr_in_if.sv]
// ----------------------------------------------------------------------------
// qvr_in_if
// Input channel: quaternion and vector to rotate, valid/ready handshake.
// ----------------------------------------------------------------------------
interface qvr_in_if #(
	parameter int VEC_WIDTH = 16
) ();
	logic                        valid;
	logic                        ready;
	logic signed [15:0]          quat_w;
	logic signed [15:0]          quat_x;
	logic signed [15:0]          quat_y;
	logic signed [15:0]          quat_z;
	logic signed [VEC_WIDTH-1:0] vec_x;
	logic signed [VEC_WIDTH-1:0] vec_y;
	logic signed [VEC_WIDTH-1:0] vec_z;

	modport source (output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
		input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
		output ready);
endinterface

[hdl/qvr_out_if.sv]
// ----------------------------------------------------------------------------
// qvr_out_if
// Output channel: rotated vector, valid/ready handshake.
// ----------------------------------------------------------------------------
interface qvr_out_if #(
	parameter int VEC_WIDTH = 16
) ();
	logic                        valid;
	logic                        ready;
	logic signed [VEC_WIDTH-1:0] rot_x;
	logic signed [VEC_WIDTH-1:0] rot_y;
	logic signed [VEC_WIDTH-1:0] rot_z;

	modport source (output valid, rot_x, rot_y, rot_z, input ready);
	modport sink (input valid, rot_x, rot_y, rot_z, output ready);
endinterface

[hdl/qvr_div.sv]
// ----------------------------------------------------------------------------
// qvr_div
// Pipelined restoring divider, three lanes sharing one divisor, one quotient
// bit per stage. Each stage holds when the one after it is full and stalled.
// ----------------------------------------------------------------------------
module qvr_div #(
	parameter int VEC_WIDTH = qvr_pkg::VEC_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [qvr_pkg::MAT_W+VEC_WIDTH+1:0]    in_mag [3],
	input  logic [qvr_pkg::NRM_W-1:0]              in_n,
	input  qvr_pkg::side_t                         in_side,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [VEC_WIDTH:0]                     out_q [3],
	output logic [qvr_pkg::MAT_W+VEC_WIDTH+1:0]    out_rem [3],
	output logic [qvr_pkg::NRM_W-1:0]              out_n,
	output qvr_pkg::side_t                         out_side
);
	import qvr_pkg::*;

	localparam int DW = MAT_W + VEC_WIDTH + 2;  // dividend width
	localparam int QB = VEC_WIDTH + 1;          // quotient bits

	// index 0 is the input, index t+1 is the register of stage t
	logic             vld_s  [QB+1];
	logic [DW-1:0]    rem_s  [QB+1][3];
	logic [QB-1:0]    q_s    [QB+1][3];
	logic [NRM_W-1:0] n_s    [QB+1];
	side_t            side_s [QB+1];
	logic             en     [QB+1];

	assign vld_s[0]  = in_valid;
	assign n_s[0]    = in_n;
	assign side_s[0] = in_side;
	assign en[QB]    = out_ready;
	assign in_ready  = en[0];

	for (genvar l = 0; l < 3; l++) begin : g_in
		assign rem_s[0][l] = in_mag[l];
		assign q_s[0][l]   = '0;
	end

	for (genvar t = 0; t < QB; t++) begin : g_stage
		localparam int B = QB - 1 - t;  // quotient bit decided here

		logic [DW-1:0] nsh;
		logic [DW-1:0] rem_nx [3];
		logic [QB-1:0] q_nx   [3];

		// stage may load when empty or when its content moves on
		assign en[t] = !vld_s[t+1] || en[t+1];

		// trial subtract of the shifted divisor
		assign nsh = DW'(n_s[t]) << B;
		for (genvar l = 0; l < 3; l++) begin : g_lane
			always_comb begin
				if (rem_s[t][l] >= nsh) begin
					rem_nx[l] = rem_s[t][l] - nsh;
					q_nx[l]   = q_s[t][l] | (QB'(1) << B);
				end else begin
					rem_nx[l] = rem_s[t][l];
					q_nx[l]   = q_s[t][l];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[t+1] <= 1'b0;
			end else if (en[t]) begin
				vld_s[t+1] <= vld_s[t];
			end
		end

		always_ff @(posedge clk) begin
			if (en[t] && vld_s[t]) begin
				rem_s[t+1]  <= rem_nx;
				q_s[t+1]    <= q_nx;
				n_s[t+1]    <= n_s[t];
				side_s[t+1] <= side_s[t];
			end
		end
	end

	assign out_valid = vld_s[QB];
	assign out_q     = q_s[QB];
	assign out_rem   = rem_s[QB];
	assign out_n     = n_s[QB];
	assign out_side  = side_s[QB];

endmodule

[hdl/quaternion_vector_rotation.sv]
// ----------------------------------------------------------------------------
// quaternion_vector_rotation
// Rotates a Q8.8 vector by the normalized Q2.14 quaternion. Evaluates
// q (0,v) conj(q) / |q|^2 exactly, rounds half away from zero, saturates.
//
//   channel | dir | fields                                  | handshake
//   quat    | in  | quat_w/x/y/z, vec_x/y/z                 | valid/ready
//   rot     | out | rot_x, rot_y, rot_z                     | valid/ready
//
// One item per cycle sustained while rot is ready. The pipeline has
// five arithmetic stages, VEC_WIDTH+1 divider stages of one quotient bit
// each, one rounding/output stage. The bit-per-stage divider sets the depth.
// Reset clears only the valid bits. A stall at rot backs up stage by stage;
// empty stages keep filling, so bubbles are squeezed out.
// ----------------------------------------------------------------------------
module quaternion_vector_rotation #(
	parameter int VEC_WIDTH = qvr_pkg::VEC_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	qvr_in_if.sink    quat,
	qvr_out_if.source rot
);
	import qvr_pkg::*;

	localparam int PW = MAT_W + VEC_WIDTH;      // matrix entry times coordinate
	localparam int DW = MAT_W + VEC_WIDTH + 2;  // dot product
	localparam int QB = VEC_WIDTH + 1;          // quotient bits
	localparam int RW = QB + 2;                 // signed rounded result

	localparam logic signed [RW-1:0] SAT_HI = $signed({3'b000, 1'b0, {(VEC_WIDTH-1){1'b1}}});
	localparam logic signed [RW-1:0] SAT_LO = $signed({3'b111, 1'b1, {(VEC_WIDTH-1){1'b0}}});

	// stage enables
	logic en1, en2, en3, en4, en5, en_o;
	logic div_in_ready, div_out_valid;

	// stage 1: products of quaternion parts
	logic                        v_s1, v_s2, v_s3, v_s4, v_s5, ov_q;
	logic signed [SQ_W-1:0]      ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [SQ_W-1:0]      xy_s1, wz_s1, xz_s1, wy_s1, yz_s1, wx_s1;
	logic signed [VEC_WIDTH-1:0] vec_s1 [3];
	// stage 2: rotation matrix and norm
	logic signed [MAT_W-1:0]     m_s2 [3][3];
	logic [NRM_W-1:0]            n_s2;
	logic signed [VEC_WIDTH-1:0] vec_s2 [3];
	// stage 3: partial products
	logic signed [PW-1:0]        p_s3 [3][3];
	logic [NRM_W-1:0]            n_s3;
	logic                        zero_s3;
	// stage 4: dot products
	logic signed [DW-1:0]        dot_s4 [3];
	logic [NRM_W-1:0]            n_s4;
	logic                        zero_s4;
	// stage 5: magnitude and sign
	logic [DW-1:0]               mag_s5 [3];
	logic [NRM_W-1:0]            n_s5;
	side_t                       side_s5;
	// divider output
	logic [QB-1:0]               dq [3];
	logic [DW-1:0]               drem [3];
	logic [NRM_W-1:0]            dn;
	side_t                       dside;
	// output stage
	logic signed [VEC_WIDTH-1:0] rot_q [3];
	logic signed [VEC_WIDTH-1:0] rot_nx [3];

	// a stage loads when empty or when its item moves on
	assign en_o       = !ov_q || rot.ready;
	assign en5        = !v_s5 || div_in_ready;
	assign en4        = !v_s4 || en5;
	assign en3        = !v_s3 || en4;
	assign en2        = !v_s2 || en3;
	assign en1        = !v_s1 || en2;
	assign quat.ready = en1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (en1)  v_s1 <= quat.valid;
			if (en2)  v_s2 <= v_s1;
			if (en3)  v_s3 <= v_s2;
			if (en4)  v_s4 <= v_s3;
			if (en5)  v_s5 <= v_s4;
			if (en_o) ov_q <= div_out_valid;
		end
	end

	// stage 1: ten 16x16 products
	always_ff @(posedge clk) begin
		if (en1 && quat.valid) begin
			ww_s1  <= quat.quat_w * quat.quat_w;
			xx_s1  <= quat.quat_x * quat.quat_x;
			yy_s1  <= quat.quat_y * quat.quat_y;
			zz_s1  <= quat.quat_z * quat.quat_z;
			xy_s1  <= quat.quat_x * quat.quat_y;
			wz_s1  <= quat.quat_w * quat.quat_z;
			xz_s1  <= quat.quat_x * quat.quat_z;
			wy_s1  <= quat.quat_w * quat.quat_y;
			yz_s1  <= quat.quat_y * quat.quat_z;
			wx_s1  <= quat.quat_w * quat.quat_x;
			vec_s1 <= '{quat.vec_x, quat.vec_y, quat.vec_z};
		end
	end

	// stage 2: unnormalized rotation matrix and squared norm
	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			m_s2[0][0] <= MAT_W'(ww_s1) + MAT_W'(xx_s1) - MAT_W'(yy_s1) - MAT_W'(zz_s1);
			m_s2[0][1] <= (MAT_W'(xy_s1) - MAT_W'(wz_s1)) <<< 1;
			m_s2[0][2] <= (MAT_W'(xz_s1) + MAT_W'(wy_s1)) <<< 1;
			m_s2[1][0] <= (MAT_W'(xy_s1) + MAT_W'(wz_s1)) <<< 1;
			m_s2[1][1] <= MAT_W'(ww_s1) - MAT_W'(xx_s1) + MAT_W'(yy_s1) - MAT_W'(zz_s1);
			m_s2[1][2] <= (MAT_W'(yz_s1) - MAT_W'(wx_s1)) <<< 1;
			m_s2[2][0] <= (MAT_W'(xz_s1) - MAT_W'(wy_s1)) <<< 1;
			m_s2[2][1] <= (MAT_W'(yz_s1) + MAT_W'(wx_s1)) <<< 1;
			m_s2[2][2] <= MAT_W'(ww_s1) - MAT_W'(xx_s1) - MAT_W'(yy_s1) + MAT_W'(zz_s1);
			n_s2       <= NRM_W'($unsigned(ww_s1)) + NRM_W'($unsigned(xx_s1))
				+ NRM_W'($unsigned(yy_s1)) + NRM_W'($unsigned(zz_s1));
			vec_s2     <= vec_s1;
		end
	end

	// stage 3: matrix entries times coordinates
	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					p_s3[i][j] <= PW'(m_s2[i][j]) * PW'(vec_s2[j]);
				end
			end
			n_s3    <= n_s2;
			zero_s3 <= (n_s2 == '0);
		end
	end

	// stage 4: row sums
	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			for (int i = 0; i < 3; i++) begin
				dot_s4[i] <= DW'(p_s3[i][0]) + DW'(p_s3[i][1]) + DW'(p_s3[i][2]);
			end
			n_s4    <= n_s3;
			zero_s4 <= zero_s3;
		end
	end

	// stage 5: split into sign and magnitude for the divider
	always_ff @(posedge clk) begin
		if (en5 && v_s4) begin
			for (int i = 0; i < 3; i++) begin
				side_s5.neg[i] <= dot_s4[i][DW-1];
				mag_s5[i]      <= dot_s4[i][DW-1] ? DW'(-dot_s4[i]) : DW'(dot_s4[i]);
			end
			side_s5.zero <= zero_s4;
			n_s5         <= n_s4;
		end
	end

	qvr_div #(
		.VEC_WIDTH (VEC_WIDTH)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.in_ready  (div_in_ready),
		.in_mag    (mag_s5),
		.in_n      (n_s5),
		.in_side   (side_s5),
		.out_valid (div_out_valid),
		.out_ready (en_o),
		.out_q     (dq),
		.out_rem   (drem),
		.out_n     (dn),
		.out_side  (dside)
	);

	// round half up on the magnitude, restore sign, saturate
	for (genvar l = 0; l < 3; l++) begin : g_round
		logic              up;
		logic [QB:0]       qr;
		logic signed [RW-1:0] sv;
		always_comb begin
			up = ((DW+1)'(drem[l]) << 1) >= (DW+1)'(dn);
			qr = (QB+1)'(dq[l]) + (QB+1)'(up);
			sv = dside.neg[l] ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
			if (dside.zero) begin
				rot_nx[l] = '0;
			end else if (sv > SAT_HI) begin
				rot_nx[l] = SAT_HI[VEC_WIDTH-1:0];
			end else if (sv < SAT_LO) begin
				rot_nx[l] = SAT_LO[VEC_WIDTH-1:0];
			end else begin
				rot_nx[l] = sv[VEC_WIDTH-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en_o && div_out_valid) begin
			rot_q <= rot_nx;
		end
	end

	assign rot.valid = ov_q;
	assign rot.rot_x = rot_q[0];
	assign rot.rot_y = rot_q[1];
	assign rot.rot_z = rot_q[2];

	// an empty first stage always takes an item
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> quat.ready)
		else $error("empty first stage refused an item");

	// a held stage keeps its item
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !en4) |=> v_s3)
		else $error("stalled stage dropped its item");

	// zero quaternion gives zero matrix, hence nothing left over in the divider
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(div_out_valid && dside.zero) |-> (drem[0] == '0 && drem[1] == '0
			&& drem[2] == '0))
		else $error("zero quaternion produced a nonzero remainder");

	// remainder stays below the divisor
	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(div_out_valid && !dside.zero) |-> (drem[0] < DW'(dn) && drem[1] < DW'(dn)
			&& drem[2] < DW'(dn)))
		else $error("divider remainder out of range");

endmodule

[test/tb_quaternion_vector_rotation.sv]
// ----------------------------------------------------------------------------
// tb_quaternion_vector_rotation
// Self-checking bench for the quaternion vector rotation pipeline. Directed
// corner items, then random rotations with random stalls on both channels,
// each result checked in order against an exact integer predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_quaternion_vector_rotation;

	localparam int VW = qvr_pkg::VEC_WIDTH_DEF;
	localparam int LATENCY = VW + 7;

	typedef struct {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic signed [VW-1:0] z;
	} rvec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	qvr_in_if #(.VEC_WIDTH(VW)) quat ();
	qvr_out_if #(.VEC_WIDTH(VW)) rot ();

	quaternion_vector_rotation #(.VEC_WIDTH(VW)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.quat(quat.sink),
		.rot(rot.source)
	);

	always #6 clk = ~clk;

	rvec_t rotated_q[$];
	int errors = 0;
	int n_sent = 0;
	int n_recv = 0;
	bit hold_off = 1'b0;
	bit rx_stall_rand = 1'b1;

	// exact quotient m.v / n, rounded half away from zero, saturated
	function automatic logic signed [VW-1:0] rot_component(longint m0, longint m1,
		longint m2, longint v0, longint v1, longint v2, longint n);
		longint lim;
		logic signed [127:0] num, q, r;
		lim = (longint'(1) << (VW - 1)) - 1;
		num = 128'(m0) * v0 + 128'(m1) * v1 + 128'(m2) * v2;
		q = num / n;
		r = num % n;
		if (r < 0) begin
			q = q - 1;
			r = r + n;
		end
		if (2 * r > n || (2 * r == n && q >= 0))
			q = q + 1;
		if (q > lim)
			q = lim;
		if (q < -lim - 1)
			q = -lim - 1;
		return q[VW-1:0];
	endfunction

	function automatic rvec_t rotate_vec(logic signed [15:0] qw, logic signed [15:0] qx,
		logic signed [15:0] qy, logic signed [15:0] qz, logic signed [VW-1:0] vx,
		logic signed [VW-1:0] vy, logic signed [VW-1:0] vz);
		longint w, x, y, z, a, b, c, ww, xx, yy, zz, n;
		rvec_t r;
		w = qw; x = qx; y = qy; z = qz; a = vx; b = vy; c = vz;
		ww = w * w; xx = x * x; yy = y * y; zz = z * z;
		n = ww + xx + yy + zz;
		if (n == 0) begin
			r.x = '0; r.y = '0; r.z = '0;
			return r;
		end
		r.x = rot_component(ww + xx - yy - zz, 2 * (x * y - w * z), 2 * (x * z + w * y),
			a, b, c, n);
		r.y = rot_component(2 * (x * y + w * z), ww - xx + yy - zz, 2 * (y * z - w * x),
			a, b, c, n);
		r.z = rot_component(2 * (x * z - w * y), 2 * (y * z + w * x), ww - xx - yy + zz,
			a, b, c, n);
		return r;
	endfunction

	// drive one item, wait for acceptance, record the expectation;
	// valid stays high after the accepting edge so items can follow back to back
	task automatic send_item(logic [15:0] qw, logic [15:0] qx, logic [15:0] qy,
		logic [15:0] qz, logic [VW-1:0] vx, logic [VW-1:0] vy, logic [VW-1:0] vz,
		bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15));
		@(negedge clk);
		if (gap != 0) begin
			quat.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		quat.valid <= 1'b1;
		quat.quat_w <= qw; quat.quat_x <= qx; quat.quat_y <= qy; quat.quat_z <= qz;
		quat.vec_x <= vx; quat.vec_y <= vy; quat.vec_z <= vz;
		@(posedge clk);
		while (!quat.ready) @(posedge clk);
		rotated_q.push_back(rotate_vec(qw, qx, qy, qz, vx, vy, vz));
		n_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		quat.valid <= 1'b0;
		while (rotated_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 2) @(negedge clk);
	endtask

	// result receiver: random stalls, plus a long hold-off on request
	initial begin
		int stall;
		rot.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				rot.ready <= 1'b0;
			end else if (rx_stall_rand && !rot.ready && $urandom_range(0, 2) == 0) begin
				stall = $urandom_range(0, 15);
				repeat (stall) @(negedge clk);
				rot.ready <= 1'b1;
			end else begin
				rot.ready <= rx_stall_rand ? ($urandom_range(0, 3) != 0) : 1'b1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		rvec_t e;
		if (arst_n && rot.valid && rot.ready) begin
			n_recv++;
			if (rotated_q.size() == 0) begin
				$display("%0t unexpected result %0d %0d %0d", $time, rot.rot_x,
					rot.rot_y, rot.rot_z);
				errors++;
			end else begin
				e = rotated_q.pop_front();
				if (rot.rot_x !== e.x || rot.rot_y !== e.y || rot.rot_z !== e.z) begin
					$display("%0t mismatch exp %0d %0d %0d got %0d %0d %0d", $time,
						e.x, e.y, e.z, rot.rot_x, rot.rot_y, rot.rot_z);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		logic [15:0] one;
		one = 16'sd16384;
		send_item(one, 0, 0, 0, 16'h0100, 16'h0200, 16'h0300);
		send_item(0, 0, 0, 0, 16'h7fff, 16'h8000, 16'h1234);           // zero quaternion
		send_item(0, 0, 0, 0, 0, 0, 0);
		send_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff);
		send_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000);
		send_item(0, one, 0, 0, 16'h0100, 16'h0100, 16'h0100);         // 180 about x
		send_item(0, 0, one, 0, 16'h8000, 16'h7fff, 16'h0001);
		send_item(0, 0, 0, one, 16'h8000, 16'h8000, 16'h8000);
		send_item(16'd11585, 0, 0, 16'd11585, 16'h0100, 0, 0);         // 90 about z
		// long diagonal turned onto an axis: saturation
		send_item(16'd15000, 16'd4000, 16'hf000, 16'd7000, 16'h7fff, 16'h7fff, 16'h7fff);
		send_item(16'd1, 0, 0, 0, 16'h8000, 16'h8000, 16'h8000);
		send_item(0, 0, 0, 16'hffff, 16'h0001, 16'hffff, 16'h0001);
		send_item(16'd3, 16'd1, 16'd1, 16'd1, 16'h0001, 16'h0000, 16'h0000); // rounding of fractional results
		send_item(16'h8000, 0, 0, 0, 16'h8000, 16'h7fff, 16'h0000);
		send_item(16'd5, 16'hfffb, 16'd3, 16'hfffd, 16'hffff, 16'h0002, 16'hfffe);
		wait_drained();
	endtask

	task automatic send_random(bit no_gap = 0);
		logic [15:0] q[4];
		int sh;
		sh = $urandom_range(0, 15);
		foreach (q[i]) begin
			q[i] = 16'($urandom());
			if ($urandom_range(0, 3) == 0)
				q[i] = $signed(q[i]) >>> sh;       // small magnitudes too
			if ($urandom_range(0, 9) == 0)
				q[i] = 0;
		end
		if ($urandom_range(0, 49) == 0)
			q = '{0, 0, 0, 0};
		send_item(q[0], q[1], q[2], q[3], VW'($urandom()), VW'($urandom()),
			VW'($urandom()), no_gap);
	endtask

	task automatic test_random(int n);
		repeat (n) send_random();
		wait_drained();
	endtask

	// receiver holds off while items keep coming, then the sender pauses; then back-to-back items, receiver always ready
	task automatic test_backpressure();
		fork
			begin
				hold_off = 1'b1;
				repeat (4 * LATENCY) @(negedge clk);
				hold_off = 1'b0;
			end
			begin
				repeat (2 * LATENCY) send_random(1);
				@(negedge clk);
				quat.valid <= 1'b0;
			end
		join
		wait_drained();
		rx_stall_rand = 1'b0;
		repeat (60) send_random(1);
		wait_drained();
		rx_stall_rand = 1'b1;
	endtask

	initial begin
		quat.valid = 1'b0;
		quat.quat_w = '0; quat.quat_x = '0; quat.quat_y = '0; quat.quat_z = '0;
		quat.vec_x = '0; quat.vec_y = '0; quat.vec_z = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(415);
		test_backpressure();
		test_random(415);
		$display("sent %0d items (corners, zero quaternion, saturation, random)", n_sent);
		$display("checked %0d results under random and long output stalls", n_recv);
		if (errors == 0 && rotated_q.size() == 0)
			$display("[quaternion_vector_rotation] OK");
		else
			$display("[quaternion_vector_rotation] ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("[quaternion_vector_rotation] ERROR");
		$finish;
	end

endmodule
